// File: sv/srps_pkg.sv
// ----------------------------------------------------------------------------
// srps_pkg
// Shared types and constants for the stepper ramp profile sequencer.
// ----------------------------------------------------------------------------
package srps_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   localparam int OPCODE_W  = 2;
   localparam int INDEX_W   = 8;
   localparam int PERIOD_W  = 16;
   localparam int TOTAL_W   = 32;
   localparam int COMPARE_W = 15;
   localparam int PHASE_W   = 3;
   localparam int ACCEL_W   = 9;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   localparam logic [ACCEL_W-1:0] ACCEL_RESET = 9'd256;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_STOP  = 2'd3
   } op_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE   = 3'd0,
      PH_ACCEL  = 3'd1,
      PH_CRUISE = 3'd2,
      PH_DECEL  = 3'd3,
      PH_STOP   = 3'd4
   } phase_type;

   typedef struct packed {
      logic      load;
      logic      run;
      phase_type phase;
   } meta_type;

endpackage

// File: sv/srps_table.sv
// ----------------------------------------------------------------------------
// srps_table
// Ramp period table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srps_table #(
   parameter int TABLE_DEPTH = srps_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
   input  logic [srps_pkg::PERIOD_W-1:0]        wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
   output logic [srps_pkg::PERIOD_W-1:0]        rd_data
);
   import srps_pkg::*;

   logic [PERIOD_W-1:0] mem_ff [TABLE_DEPTH];
   logic [PERIOD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/srps_ctrl.sv
// ----------------------------------------------------------------------------
// srps_ctrl
// Motion state machine: decodes each beat, advances the ramp position and
// issues table reads and writes.
// ----------------------------------------------------------------------------
module srps_ctrl #(
   parameter int TABLE_DEPTH = srps_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [srps_pkg::OPCODE_W-1:0]        opcode,
   input  logic [srps_pkg::INDEX_W-1:0]         entry_index,
   input  logic [srps_pkg::PERIOD_W-1:0]        entry_period,
   input  logic [srps_pkg::TOTAL_W-1:0]         pulse_total,
   input  logic                                 csr_write,
   input  logic [srps_pkg::ACCEL_W-1:0]         csr_value,
   output logic                                 wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
   output logic [srps_pkg::PERIOD_W-1:0]        wr_data,
   output logic                                 rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
   output srps_pkg::meta_type                   meta
);
   import srps_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = $clog2(TABLE_DEPTH + 1) + 1;
   localparam logic signed [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

   phase_type               phase_ff, phase_in;
   logic signed [SW-1:0]    step_ff, step_in;
   logic signed [SW-1:0]    limit_ff, limit_in;
   logic [TOTAL_W-1:0]      done_ff, done_in;
   logic [TOTAL_W-1:0]      target_ff, target_in;
   logic                    run_ff, run_in;
   logic [ACCEL_W-1:0]      accel_ff, accel_in;

   logic [TOTAL_W-1:0]      done_inc;
   logic [TOTAL_W-1:0]      step_ext;
   logic [TOTAL_W-1:0]      left;
   logic signed [SW-1:0]    rd_pos;
   logic                    load;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         step_ff   <= '0;
         limit_ff  <= DEPTH_S;
         done_ff   <= '0;
         target_ff <= '0;
         run_ff    <= 1'b0;
         accel_ff  <= ACCEL_RESET;
      end else begin
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         limit_ff  <= limit_in;
         done_ff   <= done_in;
         target_ff <= target_in;
         run_ff    <= run_in;
         accel_ff  <= accel_in;
      end
   end

   assign done_inc = (done_ff != '1) ? done_ff + TOTAL_W'(1) : done_ff;
   assign step_ext = TOTAL_W'(step_ff);
   assign left     = (target_ff > step_ext) ? target_ff - step_ext : '0;

   always_comb begin
      phase_in  = phase_ff;
      step_in   = step_ff;
      limit_in  = limit_ff;
      done_in   = done_ff;
      target_in = target_ff;
      run_in    = run_ff;
      accel_in  = csr_write ? csr_value : accel_ff;
      load      = 1'b0;
      rd_pos    = step_ff;
      wr_en     = 1'b0;
      if (accept) begin
         unique case (op_type'(opcode))
            OP_LOAD: begin
               wr_en = (int'(entry_index) < TABLE_DEPTH);
            end
            OP_START: begin
               if (accel_ff == '0) begin
                  limit_in = SW'(1);
               end else if (int'(accel_ff) > TABLE_DEPTH) begin
                  limit_in = DEPTH_S;
               end else begin
                  limit_in = SW'(accel_ff);
               end
               done_in   = '0;
               target_in = pulse_total;
               step_in   = '0;
               phase_in  = PH_ACCEL;
               run_in    = 1'b1;
               load      = 1'b1;
               rd_pos    = '0;
            end
            OP_TICK: begin
               if (run_ff) begin
                  done_in = done_inc;
                  unique case (phase_ff)
                     PH_ACCEL: begin
                        if (step_ff < limit_ff) begin
                           load    = 1'b1;
                           step_in = step_ff + SW'(1);
                        end else begin
                           phase_in = PH_CRUISE;
                           step_in  = step_ff - SW'(1);
                        end
                     end
                     PH_CRUISE: begin
                        if (done_inc >= left) begin
                           phase_in = PH_DECEL;
                        end
                     end
                     PH_DECEL: begin
                        if (!step_ff[SW-1]) begin
                           load    = 1'b1;
                           step_in = step_ff - SW'(1);
                        end
                     end
                     PH_STOP: begin
                        if (!step_ff[SW-1] && step_ff != '0) begin
                           load    = 1'b1;
                           step_in = step_ff - SW'(1);
                        end else begin
                           run_in   = 1'b0;
                           phase_in = PH_IDLE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            OP_STOP: begin
               if (phase_ff != PH_IDLE) begin
                  phase_in = PH_STOP;
               end
            end
         endcase
      end
   end

   // read position clamped to the last entry
   always_comb begin
      if (rd_pos >= DEPTH_S) begin
         rd_addr = AW'(TABLE_DEPTH - 1);
      end else begin
         rd_addr = AW'(rd_pos);
      end
   end

   assign rd_en      = load;
   assign wr_addr    = AW'(entry_index);
   assign wr_data    = entry_period;
   assign meta.load  = load;
   assign meta.run   = run_in;
   assign meta.phase = phase_in;

endmodule

// File: sv/srps_out.sv
// ----------------------------------------------------------------------------
// srps_out
// Result stage: merges the table read with the held period and registers
// the result beat.
// ----------------------------------------------------------------------------
module srps_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  srps_pkg::meta_type                   meta,
   input  logic [srps_pkg::PERIOD_W-1:0]        rd_data,
   output logic                                 stage_ready,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [srps_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import srps_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   meta_type              meta_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [PERIOD_W-1:0]   period_now;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  advance;

   assign advance     = !rsp_valid_ff || rsp_tready;
   assign stage_ready = !s1_valid_ff || advance;
   assign period_now  = meta_ff.load ? rd_data : period_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      rsp_data_in = {(RSP_DATA_W - PERIOD_W - COMPARE_W - 1 - PHASE_W)'(0),
                     meta_ff.phase, meta_ff.run,
                     period_now[PERIOD_W-1:1], period_now};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && s1_valid_ff) begin
            period_ff <= period_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta;
      end
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/stepper_ramp_profile_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_ramp_profile_sequencer
// Per-pulse speed ramp for a stepper drive, built around a period table.
// Each request beat is registered at the table read and meta stage, then at the result register.
// Throughput: one request beat per cycle while the result beat does not stall, set by the single table read port.
// Reset clears the motion state and sets accel_steps to 256; the table holds
// its contents and reads of unloaded entries are undefined.
// ----------------------------------------------------------------------------
module stepper_ramp_profile_sequencer #(
   parameter int TABLE_DEPTH = srps_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index, entry_period, pulse_total
   input  logic [srps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  logic [srps_pkg::OPCODE_W-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // period, compare, run, phase
   output logic [srps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srps_pkg::ACCEL_W-1:0]      csr_data
);
   import srps_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   logic                accept;
   logic                stage_ready;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [PERIOD_W-1:0] wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [PERIOD_W-1:0] rd_data;
   meta_type            meta;

   assign req_tready = stage_ready;
   assign accept     = req_tvalid && stage_ready;
   assign csr_ready  = 1'b1;

   srps_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_tuser),
      .entry_index  (req_tdata[INDEX_W-1:0]),
      .entry_period (req_tdata[INDEX_W+PERIOD_W-1:INDEX_W]),
      .pulse_total  (req_tdata[INDEX_W+PERIOD_W+TOTAL_W-1:INDEX_W+PERIOD_W]),
      .csr_write    (csr_valid),
      .csr_value    (csr_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .meta         (meta)
   );

   srps_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srps_out u_out (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .meta        (meta),
      .rd_data     (rd_data),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// File: sv/srps_checker.sv
// ----------------------------------------------------------------------------
// srps_checker
// Port-level checks for the stepper ramp profile sequencer.
// ----------------------------------------------------------------------------
module srps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [srps_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import srps_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // run is set exactly while a move is active
   a_run_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31] == (rsp_tdata[34:32] != PH_IDLE)))
      else $error("run and phase disagree");

   // an accepted beat always yields a result beat when rsp_tready stays high
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result beat missing");

endmodule

bind stepper_ramp_profile_sequencer srps_checker u_srps_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stepper ramp profile sequencer. A local model of
// the ramp walk predicts one result beat per request beat; a monitor compares
// every result beat field by field in order. The period table is filled up
// front, then directed moves, a full-depth ramp, an output stall and random
// moves run under several accel_steps settings with random idle cycles.
// ----------------------------------------------------------------------------
module tb_top;
   import srps_pkg::*;

   localparam int DEPTH       = TABLE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [PERIOD_W-1:0]  period;
      logic [COMPARE_W-1:0] compare;
      logic                 run;
      phase_type            phase;
   } profile_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OPCODE_W-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [ACCEL_W-1:0]    csr_data;

   // local copy of the sequencer state
   logic [PERIOD_W-1:0] period_mem [DEPTH];
   int                  step_pos;
   phase_type           move_phase;
   logic [TOTAL_W-1:0]  pulses_seen;
   logic [TOTAL_W-1:0]  pulse_goal;
   logic [PERIOD_W-1:0] cur_period;
   logic                run_on;
   logic [ACCEL_W-1:0]  accel_reg;
   int                  accel_cap;

   profile_beat_type profile_queue [$];
   profile_beat_type want_beat;

   int  err_count   = 0;
   int  items_sent  = 0;
   int  cycle_count = 0;
   bit  gap_on      = 1;
   int  stall_len   = 0;
   int  stall_seq   = 0;

   stepper_ramp_profile_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count <= CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("[stepper_ramp_profile_sequencer] ERROR");
      $finish;
   end

   function automatic int accel_clamp(logic [ACCEL_W-1:0] v);
      int c;
      c = v;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic logic [PERIOD_W-1:0] read_period(int pos);
      int p;
      p = pos;
      if (p < 0) p = 0;
      if (p > DEPTH - 1) p = DEPTH - 1;
      return period_mem[p];
   endfunction

   task automatic step_profile(op_type op, logic [INDEX_W-1:0] idx,
                               logic [PERIOD_W-1:0] per, logic [TOTAL_W-1:0] total);
      longint           left;
      profile_beat_type beat;
      case (op)
         OP_LOAD: begin
            period_mem[idx] = per;
         end
         OP_START: begin
            accel_cap   = accel_clamp(accel_reg);
            pulses_seen = '0;
            pulse_goal  = total;
            step_pos    = 0;
            move_phase  = PH_ACCEL;
            cur_period  = read_period(0);
            run_on      = 1'b1;
         end
         OP_TICK: begin
            if (run_on) begin
               if (pulses_seen != '1) pulses_seen++;
               case (move_phase)
                  PH_ACCEL: begin
                     if (step_pos < accel_cap) begin
                        cur_period = read_period(step_pos);
                        step_pos++;
                     end else begin
                        move_phase = PH_CRUISE;
                        step_pos--;
                     end
                  end
                  PH_CRUISE: begin
                     left = (longint'(pulse_goal) > longint'(step_pos)) ?
                            longint'(pulse_goal) - longint'(step_pos) : 0;
                     if (longint'(pulses_seen) >= left) move_phase = PH_DECEL;
                  end
                  PH_DECEL: begin
                     if (step_pos >= 0) begin
                        cur_period = read_period(step_pos);
                        step_pos--;
                     end
                  end
                  PH_STOP: begin
                     if (step_pos >= 1) begin
                        cur_period = read_period(step_pos);
                        step_pos--;
                     end else begin
                        run_on     = 1'b0;
                        move_phase = PH_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            if (move_phase != PH_IDLE) move_phase = PH_STOP;
         end
      endcase
      beat.period  = cur_period;
      beat.compare = cur_period[PERIOD_W-1:1];
      beat.run     = run_on;
      beat.phase   = move_phase;
      profile_queue.push_back(beat);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      err_count++;
   endtask

   // entered and left at a falling edge; tvalid stays up for a following beat
   task automatic send_item(op_type op, logic [INDEX_W-1:0] idx,
                            logic [PERIOD_W-1:0] per, logic [TOTAL_W-1:0] total);
      while (gap_on && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {total, per, idx};
      step_profile(op, idx, per, total);
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, INDEX_W'($urandom), PERIOD_W'($urandom), $urandom);
   endtask

   task automatic send_start(logic [TOTAL_W-1:0] total);
      send_item(OP_START, INDEX_W'($urandom), PERIOD_W'($urandom), total);
   endtask

   task automatic send_stop();
      send_item(OP_STOP, INDEX_W'($urandom), PERIOD_W'($urandom), $urandom);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (profile_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_accel(logic [ACCEL_W-1:0] v);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      accel_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // one start, a run of ticks with an optional early stop, then stop to idle
   task automatic run_one_move();
      int                 cap;
      int                 sel;
      int                 n;
      int                 stop_at;
      logic [TOTAL_W-1:0] total;
      cap = accel_clamp(accel_reg);
      sel = $urandom_range(0, 99);
      if (sel < 10) total = '0;
      else if (sel < 20) total = '1;
      else if (sel < 25) total = $urandom;
      else total = $urandom_range(0, 2 * cap + 8);
      send_start(total);
      if (total <= 2 * cap + 8) n = int'(total) + $urandom_range(0, 4);
      else n = $urandom_range(1, 2 * cap + 8);
      stop_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, n) : -1;
      for (int i = 0; i < n; i++) begin
         if (i == stop_at) send_stop();
         send_tick();
      end
      send_stop();
      while (run_on) send_tick();
   endtask

   task automatic noise_item();
      op_type op;
      op = op_type'($urandom_range(0, 3));
      send_item(op, INDEX_W'($urandom), PERIOD_W'($urandom), $urandom);
   endtask

   task automatic random_moves(int budget);
      int goal;
      goal = items_sent + budget;
      while (items_sent < goal) begin
         if ($urandom_range(0, 99) < 80) run_one_move();
         else noise_item();
      end
   endtask

   task automatic test_table_fill();
      logic [PERIOD_W-1:0] per;
      for (int i = 0; i < DEPTH; i++) begin
         per = PERIOD_W'($urandom);
         if (i == 0 || i == DEPTH - 2) per = '0;
         if (i == 1 || i == DEPTH - 1) per = '1;
         send_item(OP_LOAD, INDEX_W'(i), per, $urandom);
      end
      drain_results();
   endtask

   task automatic test_directed_moves();
      logic [ACCEL_W-1:0] v;
      v = 3;
      set_accel(v);
      send_start(32'd8);
      repeat (10) send_tick();
      send_stop();
      send_tick();
      // tick and stop while idle are ignored
      send_tick();
      send_stop();
      send_start('0);
      send_tick();
      send_start('1);
      repeat (2) send_tick();
      // restart during a move
      send_start(32'd5);
      send_tick();
      send_stop();
      repeat (2) send_tick();
      send_item(OP_LOAD, INDEX_W'(DEPTH - 1), '1, '0);
      send_item(OP_LOAD, '0, '0, '1);
      drain_results();
   endtask

   // full table depth without idle cycles on either side
   task automatic test_full_ramp();
      logic [ACCEL_W-1:0] v;
      v = '1;
      set_accel(v);
      gap_on = 0;
      send_start(32'd520);
      while (!(move_phase == PH_DECEL && step_pos < 0)) send_tick();
      send_tick();
      send_stop();
      send_tick();
      drain_results();
      gap_on = 1;
   endtask

   task automatic test_backpressure();
      logic [ACCEL_W-1:0] v;
      v = 8;
      set_accel(v);
      stall_len = 300;
      stall_seq++;
      send_start(32'd30);
      repeat (60) send_tick();
      drain_results();
   endtask

   task automatic test_random_moves();
      logic [ACCEL_W-1:0] v;
      v = $urandom_range(1, 8);
      set_accel(v);
      random_moves(150);
      v = $urandom_range(9, 48);
      set_accel(v);
      random_moves(100);
      drain_results();
      random_moves(100);
      v = '0;
      set_accel(v);
      random_moves(60);
      v = $urandom_range(1, DEPTH);
      set_accel(v);
      random_moves(40);
      v = 1;
      set_accel(v);
      random_moves(60);
   endtask

   // result side: random idle plus a requested long hold-off
   initial begin : rsp_sink
      int seen_seq;
      int hold;
      seen_seq = 0;
      hold     = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_seq != seen_seq) begin
            seen_seq = stall_seq;
            hold     = stall_len;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(gap_on && $urandom_range(0, 99) < 33);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (profile_queue.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[PERIOD_W-1:0], 0);
         end else begin
            want_beat = profile_queue.pop_front();
            if (rsp_tdata[15:0] !== want_beat.period)
               report_mismatch("period", rsp_tdata[15:0], want_beat.period);
            if (rsp_tdata[30:16] !== want_beat.compare)
               report_mismatch("compare", rsp_tdata[30:16], want_beat.compare);
            if (rsp_tdata[31] !== want_beat.run)
               report_mismatch("run", rsp_tdata[31], want_beat.run);
            if (rsp_tdata[34:32] !== want_beat.phase)
               report_mismatch("phase", rsp_tdata[34:32], want_beat.phase);
         end
      end
   end

   initial begin
      step_pos    = 0;
      move_phase  = PH_IDLE;
      pulses_seen = '0;
      pulse_goal  = '0;
      cur_period  = '0;
      run_on      = 1'b0;
      accel_reg   = ACCEL_RESET;
      accel_cap   = DEPTH;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_table_fill();
      test_directed_moves();
      test_full_ramp();
      test_backpressure();
      test_random_moves();
      drain_results();
      if (err_count == 0) begin
         $display("[stepper_ramp_profile_sequencer] OK");
      end else begin
         $display("[stepper_ramp_profile_sequencer] ERROR");
      end
      $finish;
   end

endmodule
